// File: rtl/core/pbc_pkg.sv
// Package for the per-subcarrier beamform combiner.
// Holds field widths, operation codes, item and control structs and the saturation function.
// No dependencies.
package pbc_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int SC_BITS         = 6;
    localparam int EL_BITS         = 2;
    localparam int ACC_BITS        = 36;
    localparam int PROD_BITS       = 2 * SAMPLE_BITS;
    localparam int DEF_ELEMENTS    = 4;
    localparam int DEF_SUBCARRIERS = 64;

    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic                          operation;
        logic [SC_BITS-1:0]            subcarrier;
        logic [EL_BITS-1:0]            element;
        logic signed [SAMPLE_BITS-1:0] value_re;
        logic signed [SAMPLE_BITS-1:0] value_im;
    } t_in_item;

    typedef struct packed {
        logic [SC_BITS-1:0]         out_subcarrier;
        logic signed [ACC_BITS-1:0] out_re;
        logic signed [ACC_BITS-1:0] out_im;
    } t_out_item;

    typedef struct packed {
        logic               valid;
        logic               last;
        logic [SC_BITS-1:0] sc;
    } t_stage_ctl;

    function automatic logic signed [ACC_BITS-1:0] sat_acc(input logic signed [ACC_BITS:0] v);
        logic signed [ACC_BITS-1:0] res;
        if (v[ACC_BITS] != v[ACC_BITS-1]) begin
            res = v[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
        end else begin
            res = v[ACC_BITS-1:0];
        end
        return res;
    endfunction

endpackage

// File: rtl/core/pbc_wstore.sv
// Complex weight memory, one entry per subcarrier and antenna element.
// Synchronous write and registered read; the read data holds until the next read.
// Depends on pbc_pkg.
module pbc_wstore #(
    parameter int DEPTH  = pbc_pkg::DEF_ELEMENTS * pbc_pkg::DEF_SUBCARRIERS,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_wr,
    input  logic                               i_rd,
    input  logic [ADDR_W-1:0]                  i_addr,
    input  logic [2*pbc_pkg::SAMPLE_BITS-1:0]  i_wdata,
    output logic [2*pbc_pkg::SAMPLE_BITS-1:0]  o_rdata
);

    logic [2*pbc_pkg::SAMPLE_BITS-1:0] mem [DEPTH];
    logic [2*pbc_pkg::SAMPLE_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_rd) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/pbc_mac.sv
// Conjugate multiply, saturating accumulation and the output register of the combiner.
// Registers four partial products, then adds them into the shared re/im accumulators.
// Depends on pbc_pkg.
module pbc_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pbc_pkg::t_stage_ctl                  i_ctl,
    input  logic signed [pbc_pkg::SAMPLE_BITS-1:0] i_s_re,
    input  logic signed [pbc_pkg::SAMPLE_BITS-1:0] i_s_im,
    input  logic signed [pbc_pkg::SAMPLE_BITS-1:0] i_w_re,
    input  logic signed [pbc_pkg::SAMPLE_BITS-1:0] i_w_im,
    output logic                                 o_stall,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output pbc_pkg::t_out_item                   o_out_data
);

    pbc_pkg::t_stage_ctl                         r_ctl;
    logic signed [pbc_pkg::PROD_BITS-1:0]        r_p_rr, r_p_ii, r_p_ir, r_p_ri;
    logic signed [pbc_pkg::ACC_BITS-1:0]         r_acc_re, r_acc_im;
    logic                                        r_out_valid;
    pbc_pkg::t_out_item                          r_out;
    logic signed [pbc_pkg::PROD_BITS:0]          w_sum_re, w_sum_im;
    logic signed [pbc_pkg::ACC_BITS:0]           w_wide_re, w_wide_im;
    logic signed [pbc_pkg::ACC_BITS-1:0]         n_acc_re, n_acc_im;
    logic                                        w_en;

    assign o_stall = r_out_valid && !i_out_ready && r_ctl.valid && r_ctl.last;
    assign w_en    = !o_stall;

    assign w_sum_re  = (pbc_pkg::PROD_BITS+1)'(r_p_rr) + (pbc_pkg::PROD_BITS+1)'(r_p_ii);
    assign w_sum_im  = (pbc_pkg::PROD_BITS+1)'(r_p_ir) - (pbc_pkg::PROD_BITS+1)'(r_p_ri);
    assign w_wide_re = (pbc_pkg::ACC_BITS+1)'(r_acc_re) + (pbc_pkg::ACC_BITS+1)'(w_sum_re);
    assign w_wide_im = (pbc_pkg::ACC_BITS+1)'(r_acc_im) + (pbc_pkg::ACC_BITS+1)'(w_sum_im);
    assign n_acc_re  = pbc_pkg::sat_acc(w_wide_re);
    assign n_acc_im  = pbc_pkg::sat_acc(w_wide_im);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p_rr <= i_s_re * i_w_re;
            r_p_ii <= i_s_im * i_w_im;
            r_p_ir <= i_s_im * i_w_re;
            r_p_ri <= i_s_re * i_w_im;
        end
        if (w_en && r_ctl.valid && r_ctl.last) begin
            r_out.out_subcarrier <= r_ctl.sc;
            r_out.out_re         <= n_acc_re;
            r_out.out_im         <= n_acc_im;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= '0;
            r_acc_re    <= '0;
            r_acc_im    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_en) begin
                r_ctl <= i_ctl;
            end
            if (w_en && r_ctl.valid) begin
                if (r_ctl.last) begin
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                end else begin
                    r_acc_re <= n_acc_re;
                    r_acc_im <= n_acc_im;
                end
            end
            if (w_en && r_ctl.valid && r_ctl.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_ctl.valid && r_ctl.last) |=> (r_acc_re == '0 && r_acc_im == '0))
        else $error("Accumulator not cleared after a result.");

    a_stall_holds_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> ($stable(r_acc_re) && $stable(r_acc_im)))
        else $error("Accumulator changed during a stall.");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_ctl.valid && r_ctl.last))
        else $error("Result raised without a last-element sample.");

endmodule

// File: rtl/core/per_subcarrier_beamform_combiner_top.sv
// Per-subcarrier beamform combiner: sums sample times conjugate weight over antenna elements.
// A last-element sample passes the stage-1 and weight-read registers, the product registers, then the output register.
// Throughput: one item per cycle; input stalls only while a result meets an untaken output register.
// Reset clears the pipeline valid bits, the accumulator and the output valid flag.
// The weight memory is not cleared; entries hold their contents only once written.
// Depends on pbc_pkg, pbc_wstore and pbc_mac.
module per_subcarrier_beamform_combiner_top #(
    parameter int ELEMENTS    = pbc_pkg::DEF_ELEMENTS,
    parameter int SUBCARRIERS = pbc_pkg::DEF_SUBCARRIERS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pbc_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pbc_pkg::t_out_item  o_out_data
);

    localparam int DEPTH  = SUBCARRIERS * ELEMENTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                                   w_stall;
    logic                                   w_accept;
    logic                                   w_in_range;
    logic                                   w_wr, w_rd;
    logic [ADDR_W-1:0]                      w_addr;
    logic [2*pbc_pkg::SAMPLE_BITS-1:0]      w_rdata;
    pbc_pkg::t_stage_ctl                    r_s1_ctl;
    logic signed [pbc_pkg::SAMPLE_BITS-1:0] r_s1_re, r_s1_im;

    assign o_in_ready = !w_stall;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_in_range = (int'(i_in_data.subcarrier) < SUBCARRIERS)
                     && (int'(i_in_data.element) < ELEMENTS);
    assign w_wr   = w_accept && w_in_range && (i_in_data.operation == pbc_pkg::OP_WEIGHT);
    assign w_rd   = w_accept && w_in_range && (i_in_data.operation == pbc_pkg::OP_SAMPLE);
    assign w_addr = ADDR_W'(int'(i_in_data.subcarrier) * ELEMENTS + int'(i_in_data.element));

    pbc_wstore #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_wstore (
        .i_clk   (i_clk),
        .i_wr    (w_wr),
        .i_rd    (w_rd),
        .i_addr  (w_addr),
        .i_wdata ({i_in_data.value_re, i_in_data.value_im}),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else if (!w_stall) begin
            r_s1_ctl.valid <= w_rd;
            r_s1_ctl.last  <= (int'(i_in_data.element) == ELEMENTS - 1);
            r_s1_ctl.sc    <= i_in_data.subcarrier;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_s1_re <= i_in_data.value_re;
            r_s1_im <= i_in_data.value_im;
        end
    end

    pbc_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_s1_ctl),
        .i_s_re      (r_s1_re),
        .i_s_im      (r_s1_im),
        .i_w_re      (w_rdata[2*pbc_pkg::SAMPLE_BITS-1:pbc_pkg::SAMPLE_BITS]),
        .i_w_im      (w_rdata[pbc_pkg::SAMPLE_BITS-1:0]),
        .o_stall     (w_stall),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
